### sv/deadline_timer_queue_defines.svh
// ----------------------------------------------------------------------------
// Deadline timer queue: assertion macros
// Shared concurrent assertion forms, synchronous to clock, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication
`define DTQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define DTQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Types and constants shared by the deadline timer queue modules.
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int TIME_BITS        = 48;
   localparam int ID_BITS          = 8;
   localparam int COUNT_BITS       = 6;

   typedef enum logic {
      OP_ARM    = 1'b0,
      OP_EXPIRE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_ARMED    = 2'd0,
      KIND_EXPIRED  = 2'd1,
      KIND_NONE_DUE = 2'd2,
      KIND_REJECTED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ARM,
      ST_EXPIRE
   } state_type;

   typedef struct packed {
      op_type               operation;
      logic [ID_BITS-1:0]   timer_id;
      logic [TIME_BITS-1:0] deadline;
      logic [TIME_BITS-1:0] now;
   } req_type;

   typedef struct packed {
      kind_type              kind;
      logic [ID_BITS-1:0]    expired_id;
      logic [TIME_BITS-1:0]  expired_deadline;
      logic                  last;
      logic [COUNT_BITS-1:0] pending_count;
      logic                  queue_empty;
      logic [TIME_BITS-1:0]  next_deadline;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // latch request word
      logic arm;       // sorted insert, one result
      logic pop;       // release head timer
      logic none_due;  // report nothing due
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic due_head;  // head entry is due at now
      logic due_next;  // second entry is due at now
   } stat_type;

endpackage

### sv/dtq_ctrl.sv
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer for the timer queue: accepts a request word, runs an insert
// step or a release loop of one timer per cycle, or reports that nothing is due.
// ----------------------------------------------------------------------------
module dtq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  dtq_pkg::op_type    operation,
   input  dtq_pkg::stat_type  stat,
   output dtq_pkg::cmd_type   cmd,
   output logic               busy
);
   import dtq_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (operation == OP_ARM) ? ST_ARM : ST_EXPIRE;
            end
         end
         ST_ARM: begin
            state_in = ST_IDLE;
         end
         ST_EXPIRE: begin
            // keep releasing while the following entry is also due
            if (!(stat.due_head && stat.due_next)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_ARM: begin
            cmd.arm = 1'b1;
         end
         ST_EXPIRE: begin
            cmd.pop      = stat.due_head;
            cmd.none_due = !stat.due_head;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

### sv/dtq_datapath.sv
// ----------------------------------------------------------------------------
// dtq_datapath
// Sorted row of timer cells with per-cell compare, occupancy count and the
// registered result word.
// ----------------------------------------------------------------------------
module dtq_datapath #(
   parameter int CAPACITY = dtq_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  dtq_pkg::req_type  req_word,
   input  dtq_pkg::cmd_type  cmd,
   output dtq_pkg::stat_type stat,
   output logic              rsp_strobe,
   output dtq_pkg::rsp_type  rsp_word
);
   import dtq_pkg::*;

   localparam int OCC_W = $clog2(CAPACITY + 1);

   req_type              req_ff;
   logic [TIME_BITS-1:0] dl_ff [CAPACITY];
   logic [TIME_BITS-1:0] dl_in [CAPACITY];
   logic [ID_BITS-1:0]   id_ff [CAPACITY];
   logic [ID_BITS-1:0]   id_in [CAPACITY];
   logic [CAPACITY-1:0]  valid_ff, valid_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic [CAPACITY-1:0]  ge;        // cell at or after insert point
   logic [CAPACITY-1:0]  take_new;  // cell receives the new timer
   logic                 full;
   logic                 insert;

   // per-cell compare against the latched deadline
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         ge[i] = !valid_ff[i] || (dl_ff[i] > req_ff.deadline);
      end
      take_new = ge & ~{ge[CAPACITY-2:0], 1'b0};
   end

   assign full          = (occ_ff == OCC_W'(CAPACITY));
   assign insert        = cmd.arm && !full;
   assign stat.due_head = valid_ff[0] && (dl_ff[0] <= req_ff.now);
   assign stat.due_next = valid_ff[1] && (dl_ff[1] <= req_ff.now);

   // cell row next values: insert shifts right from the insert point,
   // pop shifts the whole row left
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         dl_in[i] = dl_ff[i];
         id_in[i] = id_ff[i];
      end
      valid_in = valid_ff;
      occ_in   = occ_ff;
      if (insert) begin
         if (take_new[0]) begin
            dl_in[0] = req_ff.deadline;
            id_in[0] = req_ff.timer_id;
         end
         for (int i = 1; i < CAPACITY; i++) begin
            if (take_new[i]) begin
               dl_in[i] = req_ff.deadline;
               id_in[i] = req_ff.timer_id;
            end else if (ge[i]) begin
               dl_in[i] = dl_ff[i-1];
               id_in[i] = id_ff[i-1];
            end
         end
         valid_in = valid_ff | {valid_ff[CAPACITY-2:0], 1'b1};
         occ_in   = occ_ff + OCC_W'(1);
      end else if (cmd.pop) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            dl_in[i] = dl_ff[i+1];
            id_in[i] = id_ff[i+1];
         end
         valid_in = {1'b0, valid_ff[CAPACITY-1:1]};
         occ_in   = occ_ff - OCC_W'(1);
      end
   end

   // result word with queue status after this step
   always_comb begin
      rsp_strobe_in           = 1'b0;
      rsp_in                  = rsp_ff;
      if (cmd.arm) begin
         rsp_strobe_in           = 1'b1;
         rsp_in.kind             = full ? KIND_REJECTED : KIND_ARMED;
         rsp_in.expired_id       = '0;
         rsp_in.expired_deadline = '0;
         rsp_in.last             = 1'b1;
         rsp_in.pending_count    = COUNT_BITS'(occ_in);
         rsp_in.queue_empty      = 1'b0;
         rsp_in.next_deadline    = (insert && ge[0]) ? req_ff.deadline : dl_ff[0];
      end else if (cmd.pop) begin
         rsp_strobe_in           = 1'b1;
         rsp_in.kind             = KIND_EXPIRED;
         rsp_in.expired_id       = id_ff[0];
         rsp_in.expired_deadline = dl_ff[0];
         rsp_in.last             = !stat.due_next;
         rsp_in.pending_count    = COUNT_BITS'(occ_in);
         rsp_in.queue_empty      = !valid_ff[1];
         rsp_in.next_deadline    = valid_ff[1] ? dl_ff[1] : '0;
      end else if (cmd.none_due) begin
         rsp_strobe_in           = 1'b1;
         rsp_in.kind             = KIND_NONE_DUE;
         rsp_in.expired_id       = '0;
         rsp_in.expired_deadline = '0;
         rsp_in.last             = 1'b1;
         rsp_in.pending_count    = COUNT_BITS'(occ_ff);
         rsp_in.queue_empty      = !valid_ff[0];
         rsp_in.next_deadline    = valid_ff[0] ? dl_ff[0] : '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      rsp_ff <= rsp_in;
      for (int i = 0; i < CAPACITY; i++) begin
         dl_ff[i] <= dl_in[i];
         id_ff[i] <= id_in[i];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

### sv/deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Bounded min-deadline timer queue: arm inserts in sorted order, expire
// releases every due timer, earliest first, equal deadlines in arm order.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   req_word                   accepted when start && !busy
//  result    rsp_word                   valid while rsp_strobe
//
// Arm: the insert cycle follows the accept edge; the result word
// shows while the block is idle again.
// Expire: one release per cycle from the head cell of the sorted row while
// timers are due, or a single none-due word when none is.
// Reset is synchronous and empties the queue.
// The receiver cannot stall; results leave at the rate they are made.
module deadline_timer_queue #(
   parameter int CAPACITY = dtq_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dtq_pkg::req_type req_word,
   output logic             rsp_strobe,
   output dtq_pkg::rsp_type rsp_word
);
   import dtq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   dtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_word.operation),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   dtq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

### sv/dtq_checker.sv
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks on the timer queue's result sequencing and status.
// ----------------------------------------------------------------------------
`include "deadline_timer_queue_defines.svh"

module dtq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input dtq_pkg::rsp_type rsp_word
);
   import dtq_pkg::*;

   // an accepted word makes the block busy in the next cycle
   `DTQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

   // a release that is not the last is followed at once by another word
   `DTQ_ASSERT_NEXT(a_burst_cont, rsp_strobe && !rsp_word.last, rsp_strobe)

   // the last word of a request coincides with the block idle again
   `DTQ_ASSERT_NOW(a_last_idle, rsp_strobe && rsp_word.last, !busy)

   // empty status is consistent with count and next deadline
   `DTQ_ASSERT_NOW(a_empty_status, rsp_strobe && rsp_word.queue_empty,
      rsp_word.pending_count == '0 && rsp_word.next_deadline == '0)

endmodule

bind deadline_timer_queue dtq_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
